/* rtl/core/rmvs_pkg.sv */
// Shared types and fixed widths of the running mean / variance statistics block.
package rmvs_pkg;

    localparam int SUM_WIDTH     = 48;
    localparam int M2_WIDTH      = 64;
    localparam int VAR_WIDTH     = 32;
    localparam int SD_WIDTH      = 24;
    localparam int REL_WIDTH     = 32;
    localparam int DIV_NUM_WIDTH = 64;
    localparam int FRAC_BITS     = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_MEAN_UPD,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_M2_UPD,
        ST_VAR_GO,
        ST_VAR_WAIT,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_REL_GO,
        ST_REL_WAIT,
        ST_OUT
    } state_t;

endpackage

/* rtl/core/rmvs_divider.sv */
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
module rmvs_divider #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);
    localparam int CW = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [NUM_W-1:0] num_sh_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, num_sh_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_sh_reg <= num;
            den_reg    <= den;
            rem_reg    <= '0;
        end else if (busy_reg) begin
            num_sh_reg <= {num_sh_reg[NUM_W-2:0], fits};
            rem_reg    <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = num_sh_reg;
endmodule

/* rtl/core/rmvs_mul.sv */
// Shift-add serial multiplier, one multiplier bit per cycle.
module rmvs_mul #(
    parameter int OP_W = 25
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [OP_W-1:0]   a,
    input  logic [OP_W-1:0]   b,
    output logic              done,
    output logic [2*OP_W-1:0] prod
);
    localparam int PW = 2 * OP_W;
    localparam int CW = $clog2(OP_W + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CW-1:0]   cnt_reg;
    logic [PW-1:0]   acc_reg;
    logic [PW-1:0]   a_sh_reg;
    logic [OP_W-1:0] b_sh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(OP_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg  <= '0;
            a_sh_reg <= PW'(a);
            b_sh_reg <= b;
        end else if (busy_reg) begin
            if (b_sh_reg[0]) begin
                acc_reg <= acc_reg + a_sh_reg;
            end
            a_sh_reg <= {a_sh_reg[PW-2:0], 1'b0};
            b_sh_reg <= {1'b0, b_sh_reg[OP_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule

/* rtl/core/rmvs_sqrt.sv */
// Digit-by-digit integer square root, one root bit per cycle.
module rmvs_sqrt (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [2*rmvs_pkg::SD_WIDTH-1:0] rad,
    output logic                            done,
    output logic [rmvs_pkg::SD_WIDTH-1:0]   root
);
    localparam int RW = rmvs_pkg::SD_WIDTH;
    localparam int AW = 2 * RW;
    localparam int EW = RW + 3;
    localparam int CW = $clog2(RW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [AW-1:0] rad_sh_reg;
    logic [EW-1:0] rem_reg;
    logic [RW-1:0] root_reg;
    logic [EW-1:0] cur;
    logic [EW-1:0] trial;
    logic          fits;

    assign cur   = {rem_reg[EW-3:0], rad_sh_reg[AW-1:AW-2]};
    assign trial = EW'({root_reg, 2'b01});
    assign fits  = cur >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(RW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_sh_reg <= rad;
            rem_reg    <= '0;
            root_reg   <= '0;
        end else if (busy_reg) begin
            rad_sh_reg <= {rad_sh_reg[AW-3:0], 2'b00};
            rem_reg    <= fits ? cur - trial : cur;
            root_reg   <= {root_reg[RW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

/* rtl/core/running_mean_variance_stats_top.sv */
// Top level of the running mean / Welford variance statistics block.
//
//   channel   group      payload (low bit up)                                    dir
//   -------   --------   -----------------------------------------------------   ---
//   input     s_axis     tuser: action; tdata: sample                            in
//   result    m_axis     tuser: rel_valid; tdata: sample_count, minimum,         out
//                        maximum, total, mean, variance, std_dev, rel_std_dev
//
// One transaction in gives one transaction out. An add with more than one sample
// makes three passes of the shared serial divider (mean step, M2/n, std_dev/mean)
// and also runs the M2 product and the 24-bit square root. The first add skips the
// product. A zero mean skips the last division. A clear runs only the square root.
// Synchronous active-low reset clears statistics and handshake.
// The result sits in an output register; a new input is taken while it waits,
// and the pipeline holds in the final step until the register is free.
module running_mean_variance_stats_top #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COUNT_WIDTH  = 32,
    localparam int S_DATA_W    = ((SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int M_DATA_W    = ((COUNT_WIDTH + 3 * SAMPLE_WIDTH + 8 + rmvs_pkg::SUM_WIDTH
                                   + rmvs_pkg::VAR_WIDTH + rmvs_pkg::SD_WIDTH
                                   + rmvs_pkg::REL_WIDTH + 7) / 8) * 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [S_DATA_W-1:0]         s_tdata,   // sample
    input  logic [0:0]                  s_tuser,   // action
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [M_DATA_W-1:0]         m_tdata,   // count, min, max, total, mean,
                                                   // variance, std_dev, rel_std_dev
    output logic [0:0]                  m_tuser    // rel_valid
);
    localparam int MW       = SAMPLE_WIDTH + 8;            // mean width, Q.8
    localparam int DW       = MW + 1;                      // deviation width
    localparam int PW       = 2 * DW;                      // product width
    localparam int MX       = MW + 3;                      // mean update headroom
    localparam int EW       = ((PW > rmvs_pkg::M2_WIDTH) ? PW : rmvs_pkg::M2_WIDTH) + 1;
    localparam int DEN_W    = (MW > COUNT_WIDTH) ? MW : COUNT_WIDTH;
    localparam int NW       = rmvs_pkg::DIV_NUM_WIDTH;
    localparam int SDW      = rmvs_pkg::SD_WIDTH;
    localparam int VW       = rmvs_pkg::VAR_WIDTH;
    localparam int RLW      = rmvs_pkg::REL_WIDTH;
    localparam int FB       = rmvs_pkg::FRAC_BITS;

    localparam logic [MX-1:0] MEAN_MAX_X = {4'b0000, {(MW-1){1'b1}}};
    localparam logic [MX-1:0] MEAN_MIN_X = {4'b1111, {(MW-1){1'b0}}};

    rmvs_pkg::state_t state_reg, state_next;

    // statistics
    logic [COUNT_WIDTH-1:0]        count_reg;
    logic [SAMPLE_WIDTH-1:0]       min_reg;
    logic [SAMPLE_WIDTH-1:0]       max_reg;
    logic [rmvs_pkg::SUM_WIDTH-1:0] sum_reg;
    logic [MW-1:0]                 mean_reg;
    logic [rmvs_pkg::M2_WIDTH-1:0] m2_reg;

    // per-transaction work
    logic [SAMPLE_WIDTH-1:0] sample_reg;
    logic [DW-1:0]           d_mag_reg;
    logic                    d_neg_reg;
    logic [DW-1:0]           e_mag_reg;
    logic                    e_neg_reg;
    logic [VW-1:0]           var_reg;
    logic [SDW-1:0]          sd_reg;
    logic [RLW-1:0]          rel_reg;
    logic                    rel_valid_reg;

    // output register
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic                m_user_reg;

    logic                    in_fire;
    logic                    in_clear;
    logic [SAMPLE_WIDTH-1:0] in_sample;
    logic [MW-1:0]           in_s8;
    logic [DW-1:0]           d_val;
    logic [MW-1:0]           s8_reg;
    logic [DW-1:0]           e_val;
    logic [MX-1:0]           q_ext;
    logic [MX-1:0]           mean_x;
    logic [MX-1:0]           m_raw;
    logic [MW-1:0]           m_new;
    logic [EW-1:0]           m2_ext;
    logic [EW-1:0]           prod_ext;
    logic [EW-1:0]           m2_sum;
    logic [MW-1:0]           mean_mag;
    logic                    out_free;

    logic          div_start;
    logic [NW-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic          div_done;
    logic [NW-1:0] div_quo;
    logic          mul_start;
    logic          mul_done;
    logic [PW-1:0] mul_prod;
    logic          sqrt_start;
    logic          sqrt_done;
    logic [SDW-1:0] sqrt_root;

    assign s_tready  = (state_reg == rmvs_pkg::ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign in_clear  = s_tuser[0];
    assign in_sample = s_tdata[SAMPLE_WIDTH-1:0];
    assign in_s8     = {in_sample, 8'h00};
    assign d_val     = {in_s8[MW-1], in_s8} - {mean_reg[MW-1], mean_reg};
    assign out_free  = !m_valid_reg || m_tready;

    // mean step: mean +/- rounded |d|/n, clamped to the mean field
    assign q_ext  = MX'(div_quo[MW+1:0]);
    assign mean_x = {{3{mean_reg[MW-1]}}, mean_reg};
    assign m_raw  = d_neg_reg ? mean_x - q_ext : mean_x + q_ext;
    always_comb begin
        if ($signed(m_raw) > $signed(MEAN_MAX_X)) begin
            m_new = MEAN_MAX_X[MW-1:0];
        end else if ($signed(m_raw) < $signed(MEAN_MIN_X)) begin
            m_new = MEAN_MIN_X[MW-1:0];
        end else begin
            m_new = m_raw[MW-1:0];
        end
    end
    assign s8_reg = {sample_reg, 8'h00};
    assign e_val  = {s8_reg[MW-1], s8_reg} - {m_new[MW-1], m_new};

    assign m2_ext   = EW'(m2_reg);
    assign prod_ext = EW'(mul_prod);
    assign m2_sum   = m2_ext + prod_ext;
    assign mean_mag = mean_reg[MW-1] ? MW'(-mean_reg) : mean_reg;

    // shared divider operands
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (state_reg)
            rmvs_pkg::ST_MEAN_GO: begin
                div_start = 1'b1;
                div_num   = NW'(d_mag_reg) + NW'(count_reg >> 1);
                div_den   = DEN_W'(count_reg);
            end
            rmvs_pkg::ST_VAR_GO: begin
                div_start = (count_reg != '0);
                div_num   = NW'(m2_reg);
                div_den   = DEN_W'(count_reg);
            end
            rmvs_pkg::ST_REL_GO: begin
                div_start = (mean_reg != '0);
                div_num   = NW'({sd_reg, 16'h0000});
                div_den   = DEN_W'(mean_mag);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    assign mul_start  = (state_reg == rmvs_pkg::ST_MUL_GO);
    assign sqrt_start = (state_reg == rmvs_pkg::ST_SQRT_GO);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rmvs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rmvs_pkg::ST_IDLE: begin
                if (in_fire) begin
                    state_next = in_clear ? rmvs_pkg::ST_VAR_GO : rmvs_pkg::ST_MEAN_GO;
                end
            end
            rmvs_pkg::ST_MEAN_GO:   state_next = rmvs_pkg::ST_MEAN_WAIT;
            rmvs_pkg::ST_MEAN_WAIT: begin
                if (div_done) begin
                    state_next = rmvs_pkg::ST_MEAN_UPD;
                end
            end
            rmvs_pkg::ST_MEAN_UPD: begin
                state_next = (count_reg > COUNT_WIDTH'(1)) ? rmvs_pkg::ST_MUL_GO
                                                           : rmvs_pkg::ST_VAR_GO;
            end
            rmvs_pkg::ST_MUL_GO:    state_next = rmvs_pkg::ST_MUL_WAIT;
            rmvs_pkg::ST_MUL_WAIT: begin
                if (mul_done) begin
                    state_next = rmvs_pkg::ST_M2_UPD;
                end
            end
            rmvs_pkg::ST_M2_UPD:    state_next = rmvs_pkg::ST_VAR_GO;
            rmvs_pkg::ST_VAR_GO: begin
                state_next = (count_reg != '0) ? rmvs_pkg::ST_VAR_WAIT
                                               : rmvs_pkg::ST_SQRT_GO;
            end
            rmvs_pkg::ST_VAR_WAIT: begin
                if (div_done) begin
                    state_next = rmvs_pkg::ST_SQRT_GO;
                end
            end
            rmvs_pkg::ST_SQRT_GO:   state_next = rmvs_pkg::ST_SQRT_WAIT;
            rmvs_pkg::ST_SQRT_WAIT: begin
                if (sqrt_done) begin
                    state_next = rmvs_pkg::ST_REL_GO;
                end
            end
            rmvs_pkg::ST_REL_GO: begin
                state_next = (mean_reg != '0) ? rmvs_pkg::ST_REL_WAIT : rmvs_pkg::ST_OUT;
            end
            rmvs_pkg::ST_REL_WAIT: begin
                if (div_done) begin
                    state_next = rmvs_pkg::ST_OUT;
                end
            end
            rmvs_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = rmvs_pkg::ST_IDLE;
                end
            end
            default: state_next = rmvs_pkg::ST_IDLE;
        endcase
    end

    // statistics and per-transaction datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            min_reg   <= {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
            max_reg   <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
            sum_reg   <= '0;
            mean_reg  <= '0;
            m2_reg    <= '0;
        end else begin
            case (state_reg)
                rmvs_pkg::ST_IDLE: begin
                    if (in_fire && in_clear) begin
                        count_reg <= '0;
                        min_reg   <= {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
                        max_reg   <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
                        sum_reg   <= '0;
                        mean_reg  <= '0;
                        m2_reg    <= '0;
                    end else if (in_fire) begin
                        if (count_reg != {COUNT_WIDTH{1'b1}}) begin
                            count_reg <= count_reg + 1'b1;
                        end
                        sum_reg <= sum_reg + rmvs_pkg::SUM_WIDTH'($signed(in_sample));
                        if ($signed(in_sample) > $signed(max_reg)) begin
                            max_reg <= in_sample;
                        end
                        if ($signed(in_sample) < $signed(min_reg)) begin
                            min_reg <= in_sample;
                        end
                    end
                end
                rmvs_pkg::ST_MEAN_UPD: begin
                    mean_reg <= m_new;
                end
                rmvs_pkg::ST_M2_UPD: begin
                    if (d_neg_reg == e_neg_reg) begin
                        // saturate at all ones
                        m2_reg <= (m2_sum[EW-1:rmvs_pkg::M2_WIDTH] != '0)
                                  ? {rmvs_pkg::M2_WIDTH{1'b1}}
                                  : m2_sum[rmvs_pkg::M2_WIDTH-1:0];
                    end else begin
                        m2_reg <= (prod_ext > m2_ext) ? '0
                                  : rmvs_pkg::M2_WIDTH'(m2_ext - prod_ext);
                    end
                end
                default: begin
                    m2_reg <= m2_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            rmvs_pkg::ST_IDLE: begin
                sample_reg <= in_sample;
                d_neg_reg  <= d_val[DW-1];
                d_mag_reg  <= d_val[DW-1] ? DW'(-d_val) : d_val;
            end
            rmvs_pkg::ST_MEAN_UPD: begin
                e_neg_reg <= e_val[DW-1];
                e_mag_reg <= e_val[DW-1] ? DW'(-e_val) : e_val;
            end
            rmvs_pkg::ST_VAR_GO: begin
                var_reg <= '0;
            end
            rmvs_pkg::ST_VAR_WAIT: begin
                if (div_done) begin
                    var_reg <= (div_quo[NW-1:VW+FB] != '0) ? {VW{1'b1}}
                                                            : div_quo[VW+FB-1:FB];
                end
            end
            rmvs_pkg::ST_SQRT_WAIT: begin
                if (sqrt_done) begin
                    sd_reg <= sqrt_root;
                end
            end
            rmvs_pkg::ST_REL_GO: begin
                rel_reg       <= '0;
                rel_valid_reg <= (mean_reg != '0);
            end
            rmvs_pkg::ST_REL_WAIT: begin
                if (div_done) begin
                    if (!mean_reg[MW-1]) begin
                        rel_reg <= (div_quo > NW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                                  : div_quo[RLW-1:0];
                    end else begin
                        rel_reg <= (div_quo > NW'(32'h8000_0000)) ? 32'h8000_0000
                                                                  : RLW'(-div_quo[RLW-1:0]);
                    end
                end
            end
            default: begin
                sample_reg <= sample_reg;
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == rmvs_pkg::ST_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == rmvs_pkg::ST_OUT && out_free) begin
            m_data_reg <= M_DATA_W'({rel_reg, sd_reg, var_reg, mean_reg, sum_reg,
                                     max_reg, min_reg, count_reg});
            m_user_reg <= rel_valid_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

    rmvs_divider #(
        .NUM_W (NW),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    rmvs_mul #(
        .OP_W (DW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (d_mag_reg),
        .b       (e_mag_reg),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    rmvs_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .rad     ({var_reg, 16'h0000}),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );
endmodule

/* dv/running_mean_variance_stats_top_tb.sv */
// Testbench for the running mean / Welford variance statistics block.
`timescale 1ns / 1ps

module running_mean_variance_stats_top_tb;

    localparam int SW        = 16;
    localparam int CW        = 32;
    localparam int MW        = SW + 8;
    localparam int S_W       = 16;
    localparam int M_W       = 224;
    localparam int STALL_MAX = 5000;
    localparam int DRAIN     = 400;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef struct packed {
        logic [CW-1:0]                  cnt;
        logic signed [SW-1:0]           mn;
        logic signed [SW-1:0]           mx;
        logic [rmvs_pkg::SUM_WIDTH-1:0] tot;
        logic signed [MW-1:0]           mu;
        logic [rmvs_pkg::VAR_WIDTH-1:0] vr;
        logic [rmvs_pkg::SD_WIDTH-1:0]  sd;
        logic [rmvs_pkg::REL_WIDTH-1:0] rel;
        logic                           rv;
    } stats_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [S_W-1:0]   s_tdata = '0;
    logic [0:0]       s_tuser = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [M_W-1:0]   m_tdata;
    logic [0:0]       m_tuser;

    // predictor state
    longint unsigned  n_acc;
    longint           min_acc, max_acc, mean_acc;
    logic [rmvs_pkg::SUM_WIDTH-1:0] sum_acc;
    logic [63:0]      m2_acc;

    stats_t           stats_q[$];
    int               err_cnt = 0;
    int               quiet_cycles = 0;
    bit               idle_on = 1'b1;

    running_mean_variance_stats_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #10 aclk = ~aclk;

    function automatic longint unsigned mag64(longint x);
        return (x < 0) ? longint'(-x) : longint'(x);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic void clear_stats();
        n_acc    = 0;
        min_acc  = 32767;
        max_acc  = -32768;
        sum_acc  = '0;
        mean_acc = 0;
        m2_acc   = '0;
    endfunction

    // Welford update plus derived outputs for one transaction
    function automatic stats_t predict_stats(logic act, logic signed [SW-1:0] smp);
        stats_t r;
        longint s, d, e, m;
        longint unsigned q, vr, sd, rr;
        logic [127:0] prod;
        longint sr;
        if (act == ACT_CLEAR) begin
            clear_stats();
        end else begin
            s = smp;
            if (n_acc < 64'hFFFF_FFFF) n_acc++;
            sum_acc = sum_acc + rmvs_pkg::SUM_WIDTH'(s);
            if (s > max_acc) max_acc = s;
            if (s < min_acc) min_acc = s;
            d = s * 256 - mean_acc;
            q = (mag64(d) + n_acc / 2) / n_acc;
            m = (d < 0) ? mean_acc - longint'(q) : mean_acc + longint'(q);
            if (m > 8388607) m = 8388607;
            if (m < -8388608) m = -8388608;
            mean_acc = m;
            if (n_acc > 1) begin
                e = s * 256 - mean_acc;
                prod = 128'(mag64(d)) * 128'(mag64(e));
                if ((d < 0) == (e < 0)) begin
                    if (prod[127:64] != 0 || prod[63:0] > ~m2_acc) m2_acc = '1;
                    else m2_acc = m2_acc + prod[63:0];
                end else begin
                    if (prod[127:64] != 0 || prod[63:0] > m2_acc) m2_acc = '0;
                    else m2_acc = m2_acc - prod[63:0];
                end
            end
        end
        vr = 0;
        if (n_acc != 0) begin
            vr = (m2_acc / n_acc) >> 16;
            if (vr > 64'hFFFF_FFFF) vr = 64'hFFFF_FFFF;
        end
        sd = int_sqrt(vr << 16);
        if (sd > 64'hFF_FFFF) sd = 64'hFF_FFFF;
        r.rel = '0;
        r.rv  = 1'b0;
        if (mean_acc != 0) begin
            rr = (sd << 16) / mag64(mean_acc);
            if (mean_acc > 0) sr = (rr > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(rr);
            else sr = (rr > 64'h8000_0000) ? -64'sh8000_0000 : -longint'(rr);
            r.rel = sr[31:0];
            r.rv  = 1'b1;
        end
        r.cnt = n_acc[CW-1:0];
        r.mn  = min_acc[SW-1:0];
        r.mx  = max_acc[SW-1:0];
        r.tot = sum_acc;
        r.mu  = mean_acc[MW-1:0];
        r.vr  = vr[31:0];
        r.sd  = sd[23:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned exp_v);
        $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, exp_v);
        err_cnt++;
    endtask

    // drive one transaction; optional random gap before it
    task automatic send_item(logic act, logic [SW-1:0] smp);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = act;
        s_tdata  = smp;
        do @(posedge aclk); while (!s_tready);
        stats_q.insert(stats_q.size(), predict_stats(act, smp));
        @(negedge aclk);
    endtask

    // result side: random backpressure in bursts
    int stall_left = 0;
    always @(negedge aclk) begin
        if (!idle_on) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 18);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result check and watchdog
    always @(posedge aclk) begin
        stats_t x;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_MAX) begin
                $display("running_mean_variance_stats_top_tb: done, errors");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                if (stats_q.size() == 0) begin
                    report_mismatch("unexpected transaction", m_tdata[31:0], 0);
                end else begin
                    x = stats_q.pop_front();
                    if (m_tdata[31:0] !== x.cnt) report_mismatch("count", m_tdata[31:0], x.cnt);
                    if (m_tdata[47:32] !== x.mn) report_mismatch("min", m_tdata[47:32], x.mn);
                    if (m_tdata[63:48] !== x.mx) report_mismatch("max", m_tdata[63:48], x.mx);
                    if (m_tdata[111:64] !== x.tot) report_mismatch("total", m_tdata[111:64], x.tot);
                    if (m_tdata[135:112] !== x.mu) report_mismatch("mean", m_tdata[135:112], x.mu);
                    if (m_tdata[167:136] !== x.vr) report_mismatch("variance", m_tdata[167:136], x.vr);
                    if (m_tdata[191:168] !== x.sd) report_mismatch("std_dev", m_tdata[191:168], x.sd);
                    if (m_tdata[223:192] !== x.rel) report_mismatch("rel_std_dev", m_tdata[223:192], x.rel);
                    if (m_tuser[0] !== x.rv) report_mismatch("rel_valid", m_tuser[0], x.rv);
                end
            end
        end
    end

    // empty stats, field extremes, min/max tracking
    task automatic test_extremes();
        send_item(ACT_CLEAR, 16'h0000);
        send_item(ACT_ADD, 16'h7FFF);
        send_item(ACT_ADD, 16'h8000);
        send_item(ACT_ADD, 16'h8000);
        send_item(ACT_ADD, 16'h7FFF);
        send_item(ACT_ADD, 16'h0000);
        send_item(ACT_ADD, 16'hFFFF);
        send_item(ACT_ADD, 16'h0001);
        send_item(ACT_CLEAR, 16'hFFFF);
        send_item(ACT_ADD, 16'h8000);
        send_item(ACT_ADD, 16'h8000);
        send_item(ACT_CLEAR, 16'h5A5A);
    endtask

    // mean returns to zero: rel_valid drops
    task automatic test_zero_mean();
        send_item(ACT_ADD, 16'h0100);
        send_item(ACT_ADD, 16'hFF00);
        send_item(ACT_ADD, 16'h0000);
        send_item(ACT_CLEAR, 16'h0000);
        send_item(ACT_ADD, 16'h0000);
        send_item(ACT_ADD, 16'h0000);
        send_item(ACT_ADD, 16'h0003);
        send_item(ACT_ADD, 16'hFFFD);
        send_item(ACT_CLEAR, 16'h0000);
    endtask

    // runs of random samples, various spreads, occasional clear
    task automatic test_random(int n_items);
        int k;
        logic [SW-1:0] v;
        for (k = 0; k < n_items; k++) begin
            if (k > n_items - 150) idle_on = 1'b0;
            if ($urandom_range(0, 39) == 0) begin
                send_item(ACT_CLEAR, SW'($urandom));
            end else begin
                case ($urandom_range(0, 3))
                    0: v = SW'($urandom);
                    1: v = SW'($urandom_range(0, 255)) - SW'(128);
                    2: v = SW'(16'h1000 + $urandom_range(0, 31));
                    default: v = $urandom_range(0, 1) ? 16'h7FFF - SW'($urandom_range(0, 3))
                                                      : 16'h8000 + SW'($urandom_range(0, 3));
                endcase
                send_item(ACT_ADD, v);
            end
        end
        s_tvalid = 1'b0;
    endtask

    initial begin
        clear_stats();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_extremes();
        test_zero_mean();
        test_random(1000);
        while (stats_q.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("running_mean_variance_stats_top_tb: done, clean");
        end else begin
            $display("running_mean_variance_stats_top_tb: done, errors");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/rmvs_pkg.sv
rtl/core/rmvs_divider.sv
rtl/core/rmvs_mul.sv
rtl/core/rmvs_sqrt.sv
rtl/core/running_mean_variance_stats_top.sv
dv/running_mean_variance_stats_top_tb.sv
